[sv/swfd_pkg.sv]
// Shared types and constants for the sliding-window failure detector.
// No dependencies; every other file of the block but swfd_ram refers to this package.
`default_nettype none

package swfd_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int FLOWS_DEF         = 64;
	localparam int MAX_THRESHOLD_DEF = 16;

	// Field widths fixed by the item format
	localparam int FLOW_W   = 6;
	localparam int TIME_W   = 32;
	localparam int COUNT_W  = 5;
	localparam int THRESH_W = 5;
	localparam int WINDOW_W = 17;

	// Configuration register map
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_WINDOW    = 1'b1;

	// Register reset values
	localparam logic [THRESH_W-1:0] THRESHOLD_RST = THRESH_W'(5);
	localparam logic [WINDOW_W-1:0] WINDOW_RST    = WINDOW_W'(60);

	// One input event
	typedef struct packed {
		logic [FLOW_W-1:0] flow_index;
		logic [TIME_W-1:0] event_time;
		logic              is_failure;
	} item_t;

	// One alert
	typedef struct packed {
		logic [FLOW_W-1:0]  alert_flow;
		logic [COUNT_W-1:0] alert_count;
	} result_t;

	// Live configuration seen by the datapath
	typedef struct packed {
		logic [THRESH_W-1:0] failure_threshold;
		logic [WINDOW_W-1:0] window_seconds;
	} cfg_t;

endpackage

`default_nettype wire

[sv/swfd_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Depends on nothing; instantiated twice by the top level.
`default_nettype none

module swfd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[sv/swfd_apb.sv]
// APB configuration registers: failure threshold and window length.
// Depends on swfd_pkg for the register map, reset values and cfg_t.
`default_nettype none

module swfd_apb (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [swfd_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [swfd_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [swfd_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                    pready,
	output swfd_pkg::cfg_t                          cfg
);

	logic [swfd_pkg::THRESH_W-1:0] threshold_q;
	logic [swfd_pkg::WINDOW_W-1:0] window_q;
	logic                          wr_xfer;
	logic                          reg_sel;

	assign pready  = 1'b1;
	assign wr_xfer = psel & penable & pwrite;
	assign reg_sel = paddr[2];

	// Write registers on a completed write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= swfd_pkg::THRESHOLD_RST;
			window_q    <= swfd_pkg::WINDOW_RST;
		end else if (wr_xfer) begin
			unique case (reg_sel)
				swfd_pkg::REG_THRESHOLD: threshold_q <= pwdata[swfd_pkg::THRESH_W-1:0];
				swfd_pkg::REG_WINDOW:    window_q    <= pwdata[swfd_pkg::WINDOW_W-1:0];
				default:                 threshold_q <= threshold_q;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_sel)
			swfd_pkg::REG_THRESHOLD: prdata = swfd_pkg::APB_DATA_W'(threshold_q);
			swfd_pkg::REG_WINDOW:    prdata = swfd_pkg::APB_DATA_W'(window_q);
			default:                 prdata = '0;
		endcase
	end

	assign cfg.failure_threshold = threshold_q;
	assign cfg.window_seconds    = window_q;

endmodule

`default_nettype wire

[sv/swfd_ctrl.sv]
// Sequencer: reads a flow's ring pointers, appends the timestamp, pops expired entries
// one per cycle and writes the pointers back. Depends on swfd_pkg; drives both RAMs.
`default_nettype none

module swfd_ctrl #(
	parameter int FLOWS         = swfd_pkg::FLOWS_DEF,
	parameter int MAX_THRESHOLD = swfd_pkg::MAX_THRESHOLD_DEF,
	localparam int HW = $clog2(MAX_THRESHOLD),
	localparam int CW = $clog2(MAX_THRESHOLD + 1),
	localparam int PW = HW + CW,
	localparam int FW = (FLOWS > 1) ? $clog2(FLOWS) : 1,
	localparam int RD = FLOWS * MAX_THRESHOLD,
	localparam int RW = (RD > 1) ? $clog2(RD) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire swfd_pkg::item_t               item,
	output logic                               result_strobe,
	output swfd_pkg::result_t                  result,
	input  wire swfd_pkg::cfg_t                cfg,
	// flow pointer memory
	output logic                               ptr_we,
	output logic [FW-1:0]                      ptr_waddr,
	output logic [PW-1:0]                      ptr_wdata,
	output logic [FW-1:0]                      ptr_raddr,
	input  wire logic [PW-1:0]                 ptr_rdata,
	// timestamp ring memory
	output logic                               ring_we,
	output logic [RW-1:0]                      ring_waddr,
	output logic [swfd_pkg::TIME_W-1:0]        ring_wdata,
	output logic [RW-1:0]                      ring_raddr,
	input  wire logic [swfd_pkg::TIME_W-1:0]   ring_rdata
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_APPEND,
		ST_PRUNE
	} state_t;

	state_t                      state_q;
	logic [FW-1:0]               clr_q;
	logic [FW-1:0]               flow_q;
	logic [swfd_pkg::TIME_W-1:0] now_q;
	logic [HW-1:0]               head_q;
	logic [CW-1:0]               count_q;
	logic                        result_strobe_q;
	swfd_pkg::result_t           result_q;

	logic                        accept;
	logic                        take;
	logic [31:0]                 flow_ext;
	logic [FW-1:0]               in_flow;
	logic [HW-1:0]               head_r;
	logic [CW-1:0]               count_r;
	logic                        full;
	logic [HW:0]                 pos_sum;
	logic [HW-1:0]               wpos;
	logic [HW-1:0]               head_n;
	logic [CW-1:0]               count_n;
	logic [HW-1:0]               head_inc_q;
	logic [swfd_pkg::TIME_W-1:0] age;
	logic                        drop;
	logic                        alert;

	function automatic logic [HW-1:0] head_inc(input logic [HW-1:0] h);
		head_inc = (h == HW'(MAX_THRESHOLD - 1)) ? '0 : h + HW'(1);
	endfunction

	function automatic logic [RW-1:0] slot(input logic [FW-1:0] f, input logic [HW-1:0] p);
		slot = RW'(RW'(f) * RW'(MAX_THRESHOLD)) + RW'(p);
	endfunction

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start & (state_q == ST_IDLE);
	assign flow_ext = 32'(item.flow_index);
	assign in_flow  = flow_ext[FW-1:0];
	assign take     = accept & item.is_failure & (flow_ext < 32'(FLOWS));

	// Append: place the new stamp after the newest, or over the oldest when full
	assign {head_r, count_r} = ptr_rdata;
	assign full    = (count_r == CW'(MAX_THRESHOLD));
	assign pos_sum = {1'b0, head_r} + (HW + 1)'(count_r);
	assign wpos    = full ? head_r
	               : (pos_sum >= (HW + 1)'(MAX_THRESHOLD))
	                 ? HW'(pos_sum - (HW + 1)'(MAX_THRESHOLD)) : HW'(pos_sum);
	assign head_n  = full ? head_inc(head_r) : head_r;
	assign count_n = full ? count_r : count_r + CW'(1);

	// Prune: the last entry is the new stamp and never expires
	assign head_inc_q = head_inc(head_q);
	assign age        = now_q - ring_rdata;
	assign drop       = (count_q > CW'(1)) && (age > swfd_pkg::TIME_W'(cfg.window_seconds));
	assign alert      = 32'(count_q) >= 32'(cfg.failure_threshold);

	// Memory port control
	always_comb begin
		ptr_we     = 1'b0;
		ptr_waddr  = flow_q;
		ptr_wdata  = {head_q, count_q};
		ptr_raddr  = in_flow;
		ring_we    = 1'b0;
		ring_waddr = slot(flow_q, wpos);
		ring_wdata = now_q;
		ring_raddr = slot(flow_q, head_inc_q);
		unique case (state_q)
			ST_CLEAR: begin
				ptr_we    = 1'b1;
				ptr_waddr = clr_q;
				ptr_wdata = '0;
			end
			ST_IDLE: begin
				ptr_raddr = in_flow;
			end
			ST_APPEND: begin
				ring_we    = 1'b1;
				ring_raddr = slot(flow_q, head_n);
			end
			ST_PRUNE: begin
				if (!drop) begin
					ptr_we    = 1'b1;
					ptr_wdata = alert ? '0 : {head_q, count_q};
				end
			end
			default: begin
				ptr_we = 1'b0;
			end
		endcase
	end

	// Sequencer state and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			clr_q           <= '0;
			result_strobe_q <= 1'b0;
		end else begin
			// raise the strobe only at the end of a prune pass that alerts
			result_strobe_q <= (state_q == ST_PRUNE) && !drop && alert;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + FW'(1);
					if (clr_q == FW'(FLOWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						flow_q  <= in_flow;
						now_q   <= item.event_time;
						state_q <= ST_APPEND;
					end
				end
				ST_APPEND: begin
					head_q  <= head_n;
					count_q <= count_n;
					state_q <= ST_PRUNE;
				end
				ST_PRUNE: begin
					if (drop) begin
						head_q  <= head_inc_q;
						count_q <= count_q - CW'(1);
					end else begin
						result_q.alert_flow  <= swfd_pkg::FLOW_W'(32'(flow_q));
						result_q.alert_count <= swfd_pkg::COUNT_W'(32'(count_q));
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_strobe = result_strobe_q;
	assign result        = result_q;

	// An alert only leaves the end of a prune pass
	a_strobe_after_prune: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe_q |-> $past(state_q) == ST_PRUNE)
		else $error("alert without a prune pass");

	// A flow under pruning always holds the new stamp and never more than a full ring
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PRUNE |-> (count_q != '0) && (count_q <= CW'(MAX_THRESHOLD)))
		else $error("ring count out of range");

	// Ring position stays inside the ring
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PRUNE |-> head_q <= HW'(MAX_THRESHOLD - 1))
		else $error("ring head out of range");

	// A reported count is never zero
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe_q |-> result_q.alert_count != '0)
		else $error("alert with zero count");

endmodule

`default_nettype wire

[sv/sliding_window_failure_detector_core.sv]
// Per-flow sliding-window failure detector. An event is taken on start while busy is
// low. A non-failure event, or one whose flow is not below FLOWS, is taken but yields
// nothing and leaves busy low. After a failure is accepted, busy stays high while the
// block appends the timestamp to the flow's ring and then pops the expired timestamps
// from it (0 .. MAX_THRESHOLD-1 of them); no new event is taken until it is done.
// The ring memory delivers one timestamp per cycle while popping. An alert, if any,
// shows on result, marked by result_strobe for one cycle, in the first cycle with busy
// low after the event; it cannot be held off. After reset the block sweeps its pointer
// memory with busy high; register writes over APB are taken during that time too.
`default_nettype none

module sliding_window_failure_detector_core #(
	parameter int FLOWS         = swfd_pkg::FLOWS_DEF,
	parameter int MAX_THRESHOLD = swfd_pkg::MAX_THRESHOLD_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// event command
	input  wire logic                            start,
	output logic                                 busy,
	input  wire swfd_pkg::item_t                 item,
	// alert
	output logic                                 result_strobe,
	output swfd_pkg::result_t                    result,
	// configuration
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [swfd_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [swfd_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [swfd_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready
);

	localparam int HW = $clog2(MAX_THRESHOLD);
	localparam int CW = $clog2(MAX_THRESHOLD + 1);
	localparam int PW = HW + CW;
	localparam int FW = (FLOWS > 1) ? $clog2(FLOWS) : 1;
	localparam int RD = FLOWS * MAX_THRESHOLD;
	localparam int RW = (RD > 1) ? $clog2(RD) : 1;

	swfd_pkg::cfg_t              cfg;
	logic                        ptr_we;
	logic [FW-1:0]               ptr_waddr;
	logic [PW-1:0]               ptr_wdata;
	logic [FW-1:0]               ptr_raddr;
	logic [PW-1:0]               ptr_rdata;
	logic                        ring_we;
	logic [RW-1:0]               ring_waddr;
	logic [swfd_pkg::TIME_W-1:0] ring_wdata;
	logic [RW-1:0]               ring_raddr;
	logic [swfd_pkg::TIME_W-1:0] ring_rdata;

	// Configuration registers
	swfd_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Per-flow head and count
	swfd_ram #(
		.WIDTH (PW),
		.DEPTH (FLOWS)
	) u_ptr_ram (
		.clk   (clk),
		.we    (ptr_we),
		.waddr (ptr_waddr),
		.wdata (ptr_wdata),
		.raddr (ptr_raddr),
		.rdata (ptr_rdata)
	);

	// Failure timestamps, one ring of MAX_THRESHOLD slots per flow
	swfd_ram #(
		.WIDTH (swfd_pkg::TIME_W),
		.DEPTH (RD)
	) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// Sequencer
	swfd_ctrl #(
		.FLOWS         (FLOWS),
		.MAX_THRESHOLD (MAX_THRESHOLD)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result_strobe (result_strobe),
		.result        (result),
		.cfg           (cfg),
		.ptr_we        (ptr_we),
		.ptr_waddr     (ptr_waddr),
		.ptr_wdata     (ptr_wdata),
		.ptr_raddr     (ptr_raddr),
		.ptr_rdata     (ptr_rdata),
		.ring_we       (ring_we),
		.ring_waddr    (ring_waddr),
		.ring_wdata    (ring_wdata),
		.ring_raddr    (ring_raddr),
		.ring_rdata    (ring_rdata)
	);

endmodule

`default_nettype wire
